FILE: hw/rtl/miller_rabin_primality_test_unit_defines.svh
// Assertion macros shared by the primality test RTL.
// Compile with NO_ASSERTIONS defined to drop every check.
`ifndef MILLER_RABIN_PRIMALITY_TEST_UNIT_DEFINES_SVH
`define MILLER_RABIN_PRIMALITY_TEST_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MRPT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define MRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MRPT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/mrpt_pkg.sv
// Types and constants for the Miller-Rabin primality test unit.
// No dependencies; used by the top level and the bench.
package mrpt_pkg;

  localparam int BaseCount = 10;
  localparam int BaseIdxW  = 4;
  localparam int BaseValW  = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STRIP,
    ST_BASE,
    ST_REDUCE,
    ST_POW,
    ST_POW_END,
    ST_SQ,
    ST_MUL_WAIT,
    ST_DONE
  } state_t;

  // where a finished modular product is written
  typedef enum logic [1:0] {
    DST_R,
    DST_G,
    DST_B
  } mul_dst_t;

  function automatic logic [BaseValW-1:0] base_val(input logic [BaseIdxW-1:0] idx);
    logic [BaseValW-1:0] v;
    unique case (idx)
      4'd0:    v = 5'd2;
      4'd1:    v = 5'd3;
      4'd2:    v = 5'd5;
      4'd3:    v = 5'd7;
      4'd4:    v = 5'd11;
      4'd5:    v = 5'd13;
      4'd6:    v = 5'd17;
      4'd7:    v = 5'd19;
      4'd8:    v = 5'd23;
      4'd9:    v = 5'd29;
      default: v = 5'd2;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/mrpt_mulmod.sv
// Shared modular multiplier: (a * b) mod m by add-and-double, one multiplier bit a cycle.
// Depends on miller_rabin_primality_test_unit_defines.svh. Operands must be below m.
`include "miller_rabin_primality_test_unit_defines.svh"

module mrpt_mulmod #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  logic             busy_r, busy_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;

  logic [WIDTH:0] acc_sum, x_sum, m_ext;
  logic [WIDTH:0] acc_red, x_red;

  // sums carry one extra bit so m near 2^WIDTH still reduces correctly
  always_comb begin
    m_ext   = {1'b0, m};
    acc_sum = {1'b0, acc_r} + {1'b0, x_r};
    x_sum   = {1'b0, x_r} + {1'b0, x_r};
    acc_red = (acc_sum >= m_ext) ? (acc_sum - m_ext) : acc_sum;
    x_red   = (x_sum >= m_ext) ? (x_sum - m_ext) : x_sum;
  end

  assign done   = busy_r && (y_r == '0);
  assign result = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      x_nxt    = a;
      y_nxt    = b;
    end else if (busy_r) begin
      if (y_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (y_r[0]) begin
          acc_nxt = acc_red[WIDTH-1:0];
        end
        x_nxt = x_red[WIDTH-1:0];
        y_nxt = {1'b0, y_r[WIDTH-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  `MRPT_ASSERT_IMPLIES(a_no_restart, clk, rst_n, start, !busy_r)
  `MRPT_ASSERT_IMPLIES(a_acc_reduced, clk, rst_n, busy_r, (acc_r < m) && (x_r < m))
  `MRPT_ASSERT_NEXT(a_done_idles, clk, rst_n, done, !busy_r)

endmodule

FILE: hw/rtl/miller_rabin_primality_test_unit.sv
// Miller-Rabin primality test unit, fixed bases 2..29, one candidate at a time.
// Usage:
//   Input channel in_valid/in_ready carries one candidate per beat; only its low
//   NUM_WIDTH bits are tested. in_ready is high only while the unit is idle.
//   Output channel out_valid/out_ready carries one is_prime flag per candidate,
//   held in a register until taken; a stalled receiver simply holds the unit in
//   its done state, and the next candidate is taken after the result beat.
// Operation:
//   Values 0, 1 and the bases themselves go from ST_CHECK straight to ST_DONE.
//   Otherwise the unit strips trailing zeros of n-1 (one bit a cycle), then per
//   base runs a square-and-multiply on the single shared add-and-double
//   multiplier. The multiplier sets the rate.
// Reset:
//   rst_n is synchronous, active low; the unit returns to idle and any
//   candidate in flight is dropped.
// Depends on mrpt_pkg, mrpt_mulmod and miller_rabin_primality_test_unit_defines.svh.
`include "miller_rabin_primality_test_unit_defines.svh"

module miller_rabin_primality_test_unit #(
  parameter int NUM_WIDTH = 64,
  parameter int NUM_BASES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_candidate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_prime
);

  import mrpt_pkg::*;

  localparam int IdxW = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;
  localparam int KW   = $clog2(NUM_WIDTH);

  state_t   state_r, state_nxt;
  mul_dst_t dst_r, dst_nxt;

  logic [NUM_WIDTH-1:0] n_r, n_nxt;
  logic [NUM_WIDTH-1:0] nm1_r, nm1_nxt;
  logic [NUM_WIDTH-1:0] t_r, t_nxt;
  logic [NUM_WIDTH-1:0] e_r, e_nxt;
  logic [NUM_WIDTH-1:0] g_r, g_nxt;
  logic [NUM_WIDTH-1:0] r_r, r_nxt;
  logic [NUM_WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [KW-1:0]        j_r, j_nxt;
  logic [IdxW-1:0]      idx_r, idx_nxt;
  logic                 prime_r, prime_nxt;

  logic                 mm_start, mm_done;
  logic [NUM_WIDTH-1:0] mm_a, mm_b, mm_res;

  logic base_hit, last_base, sq_reject;
  logic [NUM_WIDTH-1:0] one_w;

  assign one_w = NUM_WIDTH'(1);

  mrpt_mulmod #(
    .WIDTH(NUM_WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .m      (n_r),
    .done   (mm_done),
    .result (mm_res)
  );

  always_comb begin
    base_hit = 1'b0;
    for (int i = 0; i < NUM_BASES; i++) begin
      if (n_r == NUM_WIDTH'(base_val(BaseIdxW'(i)))) begin
        base_hit = 1'b1;
      end
    end
  end

  assign last_base = (idx_r == IdxW'(NUM_BASES - 1));
  // a square of 1 from a root other than +-1 exposes a composite
  assign sq_reject = (mm_res == one_w) && (b_r != nm1_r) && (b_r != one_w);

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = (state_r == ST_DONE);
  assign out_is_prime = prime_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = ((n_r < NUM_WIDTH'(2)) || base_hit) ? ST_DONE : ST_STRIP;
      ST_STRIP:    if (t_r[0]) state_nxt = ST_BASE;
      ST_BASE:     state_nxt = ST_REDUCE;
      ST_REDUCE:   if (g_r < n_r) state_nxt = ST_POW;
      ST_POW:      state_nxt = (e_r == '0) ? ST_POW_END : ST_MUL_WAIT;
      ST_POW_END: begin
        if (r_r == one_w) begin
          state_nxt = last_base ? ST_DONE : ST_BASE;
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (j_r == '0) begin
          state_nxt = ((b_r != one_w) || last_base) ? ST_DONE : ST_BASE;
        end else begin
          state_nxt = ST_MUL_WAIT;
        end
      end
      ST_MUL_WAIT: begin
        if (mm_done) begin
          if (dst_r == DST_B) begin
            state_nxt = sq_reject ? ST_DONE : ST_SQ;
          end else begin
            state_nxt = ST_POW;
          end
        end
      end
      ST_DONE:     if (out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and multiplier requests
  always_comb begin
    n_nxt     = n_r;
    nm1_nxt   = nm1_r;
    t_nxt     = t_r;
    e_nxt     = e_r;
    g_nxt     = g_r;
    r_nxt     = r_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    prime_nxt = prime_r;
    dst_nxt   = dst_r;
    mm_start  = 1'b0;
    mm_a      = g_r;
    mm_b      = g_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) n_nxt = in_candidate[NUM_WIDTH-1:0];
      end
      ST_CHECK: begin
        prime_nxt = base_hit;
        t_nxt     = n_r - one_w;
        nm1_nxt   = n_r - one_w;
        k_nxt     = '0;
      end
      ST_STRIP: begin
        if (!t_r[0]) begin
          t_nxt = {1'b0, t_r[NUM_WIDTH-1:1]};
          k_nxt = k_r + KW'(1);
        end else begin
          idx_nxt = '0;
        end
      end
      ST_BASE: begin
        g_nxt = NUM_WIDTH'(base_val(BaseIdxW'(idx_r)));
      end
      ST_REDUCE: begin
        // base mod n, only matters for tiny n
        if (g_r >= n_r) begin
          g_nxt = g_r - n_r;
        end else begin
          e_nxt = t_r;
          r_nxt = one_w;
        end
      end
      ST_POW: begin
        if (e_r != '0) begin
          mm_start = 1'b1;
          if (e_r[0]) begin
            mm_a    = r_r;
            dst_nxt = DST_R;
            e_nxt   = {e_r[NUM_WIDTH-1:1], 1'b0};
          end else begin
            dst_nxt = DST_G;
            e_nxt   = {1'b0, e_r[NUM_WIDTH-1:1]};
          end
        end
      end
      ST_POW_END: begin
        b_nxt = r_r;
        j_nxt = k_r;
        if (r_r == one_w) begin
          if (last_base) prime_nxt = 1'b1;
          else           idx_nxt   = idx_r + IdxW'(1);
        end
      end
      ST_SQ: begin
        mm_a = b_r;
        mm_b = b_r;
        if (j_r == '0) begin
          if (b_r != one_w)   prime_nxt = 1'b0;
          else if (last_base) prime_nxt = 1'b1;
          else                idx_nxt   = idx_r + IdxW'(1);
        end else begin
          mm_start = 1'b1;
          dst_nxt  = DST_B;
        end
      end
      ST_MUL_WAIT: begin
        if (mm_done) begin
          unique case (dst_r)
            DST_R: r_nxt = mm_res;
            DST_G: g_nxt = mm_res;
            DST_B: begin
              if (sq_reject) begin
                prime_nxt = 1'b0;
              end else begin
                b_nxt = mm_res;
                j_nxt = j_r - KW'(1);
              end
            end
            default: r_nxt = r_r;
          endcase
        end
      end
      ST_DONE: begin
        prime_nxt = prime_r;
      end
      default: begin
        prime_nxt = prime_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dst_r   <= dst_nxt;
    n_r     <= n_nxt;
    nm1_r   <= nm1_nxt;
    t_r     <= t_nxt;
    e_r     <= e_nxt;
    g_r     <= g_nxt;
    r_r     <= r_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    idx_r   <= idx_nxt;
    prime_r <= prime_nxt;
  end

  `MRPT_ASSERT_IMPLIES(a_base_reduced, clk, rst_n, state_r == ST_POW, g_r < n_r)
  `MRPT_ASSERT_IMPLIES(a_mul_from_seq, clk, rst_n, mm_start, (state_r == ST_POW) || (state_r == ST_SQ))
  `MRPT_ASSERT_NEXT(a_accept_no_result, clk, rst_n, in_valid && in_ready, !out_valid)

endmodule

FILE: bench/miller_rabin_primality_test_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for miller_rabin_primality_test_unit: drives candidates,
// predicts each is_prime flag with its own Miller-Rabin model and compares.
// Depends on mrpt_pkg and the unit's RTL.
module miller_rabin_primality_test_unit_tb;

  localparam int NumWidth = 64;
  localparam int NumBases = mrpt_pkg::BaseCount;
  localparam int IdleLimit = 400000;
  localparam int DrainCycles = 200;
  localparam logic [63:0] CandMask =
    (NumWidth == 64) ? {64{1'b1}} : ((64'd1 << NumWidth) - 64'd1);
  // witnesses 2..29, five bits each, lowest first
  localparam logic [49:0] WitnessBases = {5'd29, 5'd23, 5'd19, 5'd17, 5'd13,
                                          5'd11, 5'd7, 5'd5, 5'd3, 5'd2};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_candidate = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_prime;

  logic        expected_flags[$];
  logic [63:0] tested_candidates[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_requests = 0;
  int          hold_off_length = 0;
  int          hold_off_served = 0;
  int          hold_off_left = 0;
  int          quiet_cycles = 0;

  miller_rabin_primality_test_unit #(
    .NUM_WIDTH(NumWidth),
    .NUM_BASES(NumBases)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_candidate(in_candidate),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_prime(out_is_prime)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // sum kept at 65 bits so moduli of 2^63 and up reduce exactly
  function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    while (y != 0) begin
      if (y[0]) begin
        acc = add_mod(acc, x, m);
      end
      y = y >> 1;
      x = add_mod(x, x, m);
    end
    return acc;
  endfunction

  function automatic logic predict_is_prime(input logic [63:0] raw);
    logic [63:0] n, t, g, e, b, sq;
    int          k;
    n = raw & CandMask;
    if (n <= 64'd1) begin
      return 1'b0;
    end
    for (int i = 0; i < NumBases; i++) begin
      if (n == 64'(WitnessBases[i*5 +: 5])) begin
        return 1'b1;
      end
    end
    t = n - 64'd1;
    k = 0;
    while (!t[0] && k < 64) begin
      t = t >> 1;
      k++;
    end
    for (int i = 0; i < NumBases; i++) begin
      g = 64'(WitnessBases[i*5 +: 5]) % n;
      e = t;
      b = 64'd1;
      while (e != 0) begin
        if (e[0]) begin
          b = mul_mod(b, g, n);
        end
        e = e >> 1;
        g = mul_mod(g, g, n);
      end
      if (b != 64'd1) begin
        for (int j = 0; j < k; j++) begin
          sq = mul_mod(b, b, n);
          // nontrivial square root of one
          if (sq == 64'd1 && b != n - 64'd1 && b != 64'd1) begin
            return 1'b0;
          end
          b = sq;
        end
        if (b != 64'd1) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------ driving

  task automatic send_candidate(input logic [63:0] cand);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_candidate = cand;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_flags.insert(expected_flags.size(), predict_is_prime(cand));
    tested_candidates.insert(tested_candidates.size(), cand);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // random candidate, mostly narrow so the run stays short
  function automatic logic [63:0] random_candidate();
    logic [63:0] v;
    int          pick, width;
    pick = $urandom_range(99);
    if (pick < 75) begin
      width = $urandom_range(16, 2);
    end else if (pick < 90) begin
      width = $urandom_range(32, 17);
    end else begin
      width = 64;
    end
    v = {$urandom, $urandom};
    if (width < 64) begin
      v = v & ((64'd1 << width) - 64'd1);
    end
    v[width-1] = 1'b1;
    // half of the narrow ones walk up to a prime, so every base gets exercised
    if (width <= 16 && $urandom_range(1) == 1) begin
      v[0] = 1'b1;
      while (!predict_is_prime(v)) begin
        v = v + 64'd2;
      end
    end
    return v;
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_special_values();
    logic [63:0] cases[$];
    cases = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd23, 64'd29, 64'd4, 64'd30, 64'd31,
              64'd9, 64'd25, 64'd561, 64'd2047, 64'd1373653, 64'd3215031751,
              64'd4294967291, 64'd4294967297, 64'd3825123056546413051,
              64'd9223372036854775783, 64'd9223372036854775808,
              64'd18446744073709551557, 64'd18446744073709551614,
              64'd18446744073709551615};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (cases[i]) begin
      send_candidate(cases[i]);
    end
  endtask

  task automatic test_random_stream(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_candidate(random_candidate());
    end
  endtask

  // receiver holds off while candidates keep coming; the unit must stall its input
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_length = 6000;
    hold_off_requests++;
    repeat (4) begin
      send_candidate(64'($urandom_range(255)));
    end
  endtask

  // ------------------------------------------------------------------ checking

  always @(negedge clk) begin
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_off_left = hold_off_length;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic        want;
    logic [63:0] cand;
    if (rst_n && out_valid && out_ready) begin
      if (expected_flags.size() == 0) begin
        $error("is_prime beat with no candidate pending: actual %0b", out_is_prime);
        error_count++;
      end else begin
        want = expected_flags.pop_front();
        cand = tested_candidates.pop_front();
        if (out_is_prime !== want) begin
          $error("is_prime for candidate %0d: expected %0b, actual %0b",
                 cand, want, out_is_prime);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("miller_rabin_primality_test_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_special_values();
    test_random_stream(20, 0, 0);
    test_random_stream(20, 45, 0);
    test_random_stream(20, 0, 45);
    test_random_stream(20, 26, 26);
    test_output_backpressure();

    while (expected_flags.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("miller_rabin_primality_test_unit verification clean");
    end else begin
      $display("miller_rabin_primality_test_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: miller_rabin_primality_test_unit.f
+incdir+hw/rtl
hw/rtl/mrpt_pkg.sv
hw/rtl/mrpt_mulmod.sv
hw/rtl/miller_rabin_primality_test_unit.sv
bench/miller_rabin_primality_test_unit_tb.sv
